// File: sv/fts_pkg.sv
// Shared types, constants and the control program of the fan tach monitor.
package fts_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int STEP_W     = 3;
    localparam int QUOT_W     = 16;
    localparam int CNT_W      = 4;
    localparam int DIVR_W     = 20;

    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_MS    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PULSES_REV   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STALL_THRESH = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STALL_WIN    = 2'd3;

    localparam logic [15:0] RST_WINDOW_MS    = 16'd1000;
    localparam logic [3:0]  RST_PULSES_REV   = 4'd2;
    localparam logic [15:0] RST_STALL_THRESH = 16'd100;
    localparam logic [7:0]  RST_STALL_WIN    = 8'd2;

    localparam logic [15:0] SPEED_SCALE = 16'd60000;

    // program step labels
    localparam logic [STEP_W-1:0] ST_IDLE = 3'd0;
    localparam logic [STEP_W-1:0] ST_TEST = 3'd1;
    localparam logic [STEP_W-1:0] ST_MUL  = 3'd2;
    localparam logic [STEP_W-1:0] ST_OVF  = 3'd3;
    localparam logic [STEP_W-1:0] ST_DIV  = 3'd4;
    localparam logic [STEP_W-1:0] ST_UPD  = 3'd5;
    localparam logic [STEP_W-1:0] ST_OUT  = 3'd6;
    localparam logic [STEP_W-1:0] ST_RET  = 3'd7;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_ACCEPT,
        OP_TEST,
        OP_MUL,
        OP_OVF,
        OP_DIV,
        OP_UPD,
        OP_OUT
    } t_op;

    typedef enum logic [2:0] {
        CD_NONE,
        CD_ALWAYS,
        CD_NO_INPUT,
        CD_NO_CLOSE,
        CD_SAT,
        CD_DIV_MORE,
        CD_OUT_BUSY
    } t_cond;

    typedef struct packed {
        t_op               op;
        t_cond             cond;
        logic [STEP_W-1:0] target;
    } t_uword;

    // datapath status seen by the sequencer
    typedef struct packed {
        logic no_input;
        logic no_close;
        logic sat;
        logic div_more;
        logic out_busy;
    } t_flags;

    // datapath control from the sequencer
    typedef struct packed {
        t_op op;
    } t_ctrl;

    function automatic t_uword ucode(input logic [STEP_W-1:0] step);
        t_uword w;
        case (step)
            ST_IDLE: w = '{op: OP_ACCEPT, cond: CD_NO_INPUT, target: ST_IDLE};
            ST_TEST: w = '{op: OP_TEST,   cond: CD_NO_CLOSE, target: ST_OUT};
            ST_MUL:  w = '{op: OP_MUL,    cond: CD_NONE,     target: ST_IDLE};
            ST_OVF:  w = '{op: OP_OVF,    cond: CD_SAT,      target: ST_UPD};
            ST_DIV:  w = '{op: OP_DIV,    cond: CD_DIV_MORE, target: ST_DIV};
            ST_UPD:  w = '{op: OP_UPD,    cond: CD_NONE,     target: ST_IDLE};
            ST_OUT:  w = '{op: OP_OUT,    cond: CD_OUT_BUSY, target: ST_OUT};
            ST_RET:  w = '{op: OP_NOP,    cond: CD_ALWAYS,   target: ST_IDLE};
            default: w = '{op: OP_NOP,    cond: CD_ALWAYS,   target: ST_IDLE};
        endcase
        return w;
    endfunction

endpackage

// File: sv/fan_tach_rpm_stall_monitor.sv
// Fan tach monitor top level: counters, speed divider datapath and stall tracking.
//
// Each input item (tach edge, millisecond tick, stall clear) produces exactly one result
// item. An item that does not close a window goes from acceptance through the test,
// output and return steps back to ready; an item that closes a window also runs the
// multiply, the overflow check, the 16-step restoring divider loop of the control
// program and the update, and skips the loop when the speed saturates at 65535. The
// result sits in an output register, so the next item is taken while it waits; a result
// not yet taken holds the program at its output step. window_done travels on o_m_tlast
// and marks the item that closed a window. Configuration writes are taken in any cycle
// out of reset and should be issued only while idle.
module fan_tach_rpm_stall_monitor (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    input  logic [7:0]                     i_s_tdata,   // tach_edge, ms_tick, clear_stall
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    output logic [31:0]                    o_m_tdata,   // rpm[16], stalled, low_windows[8]
    output logic                           o_m_tlast,   // window_done
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [fts_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [fts_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    localparam int QW = fts_pkg::QUOT_W;
    localparam int DW = fts_pkg::DIVR_W;

    fts_pkg::t_ctrl  w_ctrl;
    fts_pkg::t_flags w_flags;

    // configuration
    logic [15:0] r_window_ms;
    logic [3:0]  r_pulses_rev;
    logic [15:0] r_stall_thresh;
    logic [7:0]  r_stall_win;

    // state
    logic [15:0] r_edge;
    logic [15:0] r_tick;
    logic [15:0] r_speed;
    logic [7:0]  r_run;
    logic        r_flag;
    logic        r_mvalid;

    // datapath
    logic [2*QW-1:0]            r_dividend;
    logic [DW-1:0]              r_div;
    logic [DW-1:0]              r_rem;
    logic [QW-1:0]              r_dlo;
    logic [QW-1:0]              r_q;
    logic [fts_pkg::CNT_W-1:0]  r_cnt;
    logic                       r_sat;
    logic                       r_done;
    logic                       r_clr;
    logic [31:0]                r_odata;
    logic                       r_olast;

    logic          w_s_fire;
    logic [15:0]   w_win;
    logic [3:0]    w_ppr;
    logic          w_close;
    logic          w_ovf;
    logic [DW:0]   w_trial;
    logic [DW:0]   w_diff;
    logic          w_ge;
    logic [15:0]   w_speed;
    logic [7:0]    w_run_inc;
    logic          w_out_busy;
    logic [7:0]    w_run_out;
    logic          w_flag_out;

    fts_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flags (w_flags),
        .o_ctrl  (w_ctrl)
    );

    assign o_s_tready  = i_rst_n && (w_ctrl.op == fts_pkg::OP_ACCEPT);
    assign w_s_fire    = i_s_tvalid && o_s_tready;
    assign o_cfg_ready = i_rst_n;
    assign o_m_tvalid  = r_mvalid;
    assign o_m_tdata   = r_odata;
    assign o_m_tlast   = r_olast;

    assign w_win   = (r_window_ms == 16'd0) ? 16'd1 : r_window_ms;
    assign w_ppr   = (r_pulses_rev == 4'd0) ? 4'd1 : r_pulses_rev;
    assign w_close = r_tick >= w_win;

    // quotient overflows 16 bits exactly when the upper dividend half reaches the divisor
    assign w_ovf   = {4'd0, r_dividend[2*QW-1:QW]} >= r_div;

    assign w_trial = {r_rem, r_dlo[QW-1]};
    assign w_ge    = w_trial >= {1'b0, r_div};
    assign w_diff  = w_trial - {1'b0, r_div};

    assign w_speed    = r_sat ? 16'hFFFF : r_q;
    assign w_run_inc  = (r_run == 8'hFF) ? r_run : r_run + 8'd1;
    assign w_out_busy = r_mvalid && !i_m_tready;
    assign w_run_out  = r_clr ? 8'd0 : r_run;
    assign w_flag_out = r_clr ? 1'b0 : r_flag;

    assign w_flags.no_input = !i_s_tvalid;
    assign w_flags.no_close = !w_close;
    assign w_flags.sat      = w_ovf;
    assign w_flags.div_more = r_cnt != {fts_pkg::CNT_W{1'b1}};
    assign w_flags.out_busy = w_out_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_ms    <= fts_pkg::RST_WINDOW_MS;
            r_pulses_rev   <= fts_pkg::RST_PULSES_REV;
            r_stall_thresh <= fts_pkg::RST_STALL_THRESH;
            r_stall_win    <= fts_pkg::RST_STALL_WIN;
            r_edge         <= 16'd0;
            r_tick         <= 16'd0;
            r_speed        <= 16'd0;
            r_run          <= 8'd0;
            r_flag         <= 1'b0;
            r_mvalid       <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    fts_pkg::REG_WINDOW_MS:    r_window_ms    <= i_cfg_data;
                    fts_pkg::REG_PULSES_REV:   r_pulses_rev   <= i_cfg_data[3:0];
                    fts_pkg::REG_STALL_THRESH: r_stall_thresh <= i_cfg_data;
                    fts_pkg::REG_STALL_WIN:    r_stall_win    <= i_cfg_data[7:0];
                    default: ;
                endcase
            end
            if (w_ctrl.op == fts_pkg::OP_OUT && !w_out_busy) begin
                r_mvalid <= 1'b1;
            end else if (r_mvalid && i_m_tready) begin
                r_mvalid <= 1'b0;
            end
            case (w_ctrl.op)
                fts_pkg::OP_ACCEPT: begin
                    if (w_s_fire) begin
                        if (i_s_tdata[0] && r_edge != 16'hFFFF) r_edge <= r_edge + 16'd1;
                        if (i_s_tdata[1] && r_tick != 16'hFFFF) r_tick <= r_tick + 16'd1;
                    end
                end
                fts_pkg::OP_UPD: begin
                    r_speed <= w_speed;
                    r_edge  <= 16'd0;
                    r_tick  <= 16'd0;
                    if (w_speed < r_stall_thresh) begin
                        r_run <= w_run_inc;
                        if (w_run_inc >= r_stall_win) r_flag <= 1'b1;
                    end else begin
                        r_run  <= 8'd0;
                        r_flag <= 1'b0;
                    end
                end
                fts_pkg::OP_OUT: begin
                    if (!w_out_busy) begin
                        r_run    <= w_run_out;
                        r_flag   <= w_flag_out;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (w_ctrl.op)
            fts_pkg::OP_ACCEPT: begin
                if (w_s_fire) r_clr <= i_s_tdata[2];
            end
            fts_pkg::OP_TEST: begin
                r_done <= w_close;
            end
            fts_pkg::OP_MUL: begin
                r_dividend <= 32'(r_edge) * 32'(fts_pkg::SPEED_SCALE);
                r_div      <= DW'(r_tick) * DW'(w_ppr);
            end
            fts_pkg::OP_OVF: begin
                r_sat <= w_ovf;
                r_rem <= DW'(r_dividend[2*QW-1:QW]);
                r_dlo <= r_dividend[QW-1:0];
                r_cnt <= '0;
            end
            fts_pkg::OP_DIV: begin
                r_rem <= w_ge ? w_diff[DW-1:0] : w_trial[DW-1:0];
                r_q   <= {r_q[QW-2:0], w_ge};
                r_dlo <= {r_dlo[QW-2:0], 1'b0};
                r_cnt <= r_cnt + fts_pkg::CNT_W'(1);
            end
            fts_pkg::OP_OUT: begin
                if (!w_out_busy) begin
                    r_odata <= {7'd0, w_run_out, w_flag_out, r_speed};
                    r_olast <= r_done;
                end
            end
            default: ;
        endcase
    end

    // busy right after taking an item
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_s_fire |=> !o_s_tready)
        else $error("input accepted twice in a row");

    // a stall is never flagged without a run of low windows
    a_flag_has_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_flag |-> (r_run != 8'd0))
        else $error("stall flag set with zero low-window run");

    // partial remainder stays below the divisor throughout the loop
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ctrl.op == fts_pkg::OP_DIV) |-> (r_rem < r_div))
        else $error("divider remainder out of range");

    // closing a window restarts both counters
    a_close_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ctrl.op == fts_pkg::OP_UPD) |=> (r_edge == 16'd0) && (r_tick == 16'd0))
        else $error("counters not cleared at window close");

endmodule

// File: sv/fts_seq.sv
// Microcode sequencer: step counter, program fetch and conditional jumps.
module fts_seq (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  fts_pkg::t_flags i_flags,
    output fts_pkg::t_ctrl  o_ctrl
);

    logic [fts_pkg::STEP_W-1:0] r_step;
    logic [fts_pkg::STEP_W-1:0] n_step;
    fts_pkg::t_uword            w_word;
    logic                       w_taken;

    assign w_word     = fts_pkg::ucode(r_step);
    assign o_ctrl.op  = w_word.op;

    always_comb begin
        case (w_word.cond)
            fts_pkg::CD_NONE:     w_taken = 1'b0;
            fts_pkg::CD_ALWAYS:   w_taken = 1'b1;
            fts_pkg::CD_NO_INPUT: w_taken = i_flags.no_input;
            fts_pkg::CD_NO_CLOSE: w_taken = i_flags.no_close;
            fts_pkg::CD_SAT:      w_taken = i_flags.sat;
            fts_pkg::CD_DIV_MORE: w_taken = i_flags.div_more;
            fts_pkg::CD_OUT_BUSY: w_taken = i_flags.out_busy;
            default:              w_taken = 1'b0;
        endcase
        n_step = w_taken ? w_word.target : r_step + fts_pkg::STEP_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= fts_pkg::ST_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

endmodule
